/* design/b64_pkg.sv */
// ============================================================================
// b64_pkg
// Shared types, constants and the alphabet lookup for the base64 encoder.
// ============================================================================
package b64_pkg;

    // Input transaction: one raw byte of the message
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    // Output transaction: one encoded character
    typedef struct packed {
        logic [6:0] out_char;
        logic       last_char;
    } t_out;

    // One complete group: four sextets, pad flags per character, last mark
    typedef struct packed {
        logic [3:0][5:0] idx;
        logic [3:0]      pad;
        logic            last;
    } t_grp;

    // Handshake between the front end and the group queue
    typedef struct packed {
        logic push;
        t_grp grp;
    } t_push;

    localparam logic [6:0] PAD_CHAR = 7'h3d;

    localparam logic [1:0] POS_EMPTY = 2'd0;
    localparam logic [1:0] POS_ONE   = 2'd1;
    localparam logic [1:0] POS_TWO   = 2'd2;
    localparam logic [1:0] CHAR_LAST = 2'd3;

    // Map a sextet to its character in the standard alphabet
    function automatic logic [6:0] b64_char(input logic [5:0] v);
        logic [6:0] w;
        logic [6:0] c;
        w = {1'b0, v};
        if (v < 6'd26) begin
            c = w + 7'd65;
        end else if (v < 6'd52) begin
            c = w + 7'd71;
        end else if (v < 6'd62) begin
            c = w - 7'd4;
        end else if (v == 6'd62) begin
            c = 7'h2b;
        end else begin
            c = 7'h2f;
        end
        return c;
    endfunction

endpackage

/* design/b64_front.sv */
// ============================================================================
// b64_front
// Accepts raw bytes, holds the partial group and builds a group record
// whenever a group completes or the message ends.
// ============================================================================
module b64_front import b64_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_in   i_in_data,
    output logic  o_in_stall,
    input  logic  i_full,
    output t_push o_push
);

    logic [1:0] r_pos, n_pos;
    logic [7:0] r_p0, n_p0;
    logic [7:0] r_p1, n_p1;
    logic       w_acc;
    logic [7:0] w_b;

    assign o_in_stall = i_full;
    assign w_acc      = i_in_valid & ~i_full;
    assign w_b        = i_in_data.data_byte;

    // Classify the byte and form the group record
    always_comb begin
        n_pos       = r_pos;
        n_p0        = r_p0;
        n_p1        = r_p1;
        o_push.push = 1'b0;
        o_push.grp  = '0;
        unique case (r_pos)
            POS_EMPTY: begin
                o_push.grp.idx[0] = w_b[7:2];
                o_push.grp.idx[1] = {w_b[1:0], 4'b0000};
                o_push.grp.pad    = 4'b1100;
                o_push.grp.last   = 1'b1;
                if (w_acc) begin
                    if (i_in_data.last_byte) begin
                        o_push.push = 1'b1;
                    end else begin
                        n_p0  = w_b;
                        n_pos = POS_ONE;
                    end
                end
            end
            POS_ONE: begin
                o_push.grp.idx[0] = r_p0[7:2];
                o_push.grp.idx[1] = {r_p0[1:0], w_b[7:4]};
                o_push.grp.idx[2] = {w_b[3:0], 2'b00};
                o_push.grp.pad    = 4'b1000;
                o_push.grp.last   = 1'b1;
                if (w_acc) begin
                    if (i_in_data.last_byte) begin
                        o_push.push = 1'b1;
                        n_pos       = POS_EMPTY;
                        n_p0        = '0;
                    end else begin
                        n_p1  = w_b;
                        n_pos = POS_TWO;
                    end
                end
            end
            default: begin
                o_push.grp.idx[0] = r_p0[7:2];
                o_push.grp.idx[1] = {r_p0[1:0], r_p1[7:4]};
                o_push.grp.idx[2] = {r_p1[3:0], w_b[7:6]};
                o_push.grp.idx[3] = w_b[5:0];
                o_push.grp.pad    = 4'b0000;
                o_push.grp.last   = i_in_data.last_byte;
                if (w_acc) begin
                    o_push.push = 1'b1;
                    n_pos       = POS_EMPTY;
                    n_p0        = '0;
                    n_p1        = '0;
                end
            end
        endcase
    end

    // Hold position and pending bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_EMPTY;
            r_p0  <= '0;
            r_p1  <= '0;
        end else begin
            r_pos <= n_pos;
            r_p0  <= n_p0;
            r_p1  <= n_p1;
        end
    end

endmodule

/* design/b64_queue.sv */
// ============================================================================
// b64_queue
// Two-entry group queue between the front end and the character serializer.
// ============================================================================
module b64_queue import b64_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_full,
    output logic  o_valid,
    output t_grp  o_grp,
    input  logic  i_pop
);

    logic r_v0, n_v0;
    logic r_v1, n_v1;
    t_grp r_e0, n_e0;
    t_grp r_e1, n_e1;

    assign o_full  = r_v1;
    assign o_valid = r_v0;
    assign o_grp   = r_e0;

    // Advance on pop, then write into the first free slot
    always_comb begin
        n_v0 = r_v0;
        n_v1 = r_v1;
        n_e0 = r_e0;
        n_e1 = r_e1;
        if (i_pop) begin
            n_e0 = r_e1;
            n_v0 = r_v1;
            n_v1 = 1'b0;
        end
        if (i_push.push) begin
            if (!n_v0) begin
                n_e0 = i_push.grp;
                n_v0 = 1'b1;
            end else begin
                n_e1 = i_push.grp;
                n_v1 = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e0 <= n_e0;
        r_e1 <= n_e1;
    end

endmodule

/* design/b64_back.sv */
// ============================================================================
// b64_back
// Serializes the head group into four characters, one per cycle while the
// output is not stalled, through an output register.
// ============================================================================
module b64_back import b64_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_grp i_grp,
    output logic o_pop,
    output logic o_out_valid,
    output t_out o_out_data,
    input  logic i_out_stall
);

    logic [1:0] r_k;
    logic       r_vld;
    t_out       r_out;
    logic       w_load;
    t_out       w_nxt;

    assign w_load      = i_valid & (~r_vld | ~i_out_stall);
    assign o_pop       = w_load & (r_k == CHAR_LAST);
    assign o_out_valid = r_vld;
    assign o_out_data  = r_out;

    // Pick the character for the current slot
    always_comb begin
        w_nxt.out_char  = i_grp.pad[r_k] ? PAD_CHAR : b64_char(i_grp.idx[r_k]);
        w_nxt.last_char = i_grp.last & (r_k == CHAR_LAST);
    end

    // Advance the slot counter and hold the output while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k   <= '0;
            r_vld <= 1'b0;
        end else begin
            if (w_load) begin
                r_k   <= r_k + 2'd1;
                r_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_nxt;
        end
    end

endmodule

/* design/base64_encoder.sv */
// ============================================================================
// base64_encoder
// Streaming base64 encoder, standard alphabet with '=' padding.
// ============================================================================
// Input channel: one raw byte per transaction with a flag on the last byte
// of the message. Output channel: one ASCII character per transaction; the
// final character of a message carries last_char.
// Bytes that do not close a group are taken one per cycle while the queue
// is not full, and held in the front end. A closing byte (third of a group,
// or any last byte) writes a group record into a two-entry queue in the
// accept cycle. The back end sends four characters per group, one per cycle
// while the output is not stalled; after the closing byte is taken, the
// first is registered in a queue entry and then in the output register.
// Throughput is set by the single-character output port.
// The input stalls only while the group queue holds two records.
// A stall on the output holds the current character; the queue and the
// front end keep taking bytes until the queue fills.
// Synchronous reset empties the queue, drops the output and clears the
// group position; no clearing pass is needed.
// ============================================================================
module base64_encoder import b64_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in_data,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_out o_out_data,
    input  logic i_out_stall
);

    t_push w_push;
    logic  w_full;
    logic  w_q_vld;
    t_grp  w_q_grp;
    logic  w_pop;

    b64_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_full     (w_full),
        .o_push     (w_push)
    );

    b64_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_valid (w_q_vld),
        .o_grp   (w_q_grp),
        .i_pop   (w_pop)
    );

    b64_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_vld),
        .i_grp       (w_q_grp),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

`ifndef SYNTH
    // Front end never writes a group into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.push |-> !w_full)
        else $error("group written into full queue");

    // A last byte always closes a group
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.last_byte) |-> w_push.push)
        else $error("last byte did not produce a group");

    // Retiring a group leaves its fourth character on the output
    a_pop_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> o_out_valid)
        else $error("group retired without output");

    // Reset empties queue and output
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !w_q_vld))
        else $error("state left after reset");
`endif

endmodule
